// ===== hw/rtl/mavg_pkg.sv =====
`default_nettype none

package mavg_pkg;

   // Beat field widths
   localparam int DATA_W      = 32;
   localparam int WIN_LEN_W   = 9;
   localparam int FACTOR_W    = 18;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LEN = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_EMA_FACTOR = CSR_INDEX_W'(1);

   // Register reset values
   localparam logic [WIN_LEN_W-1:0] WIN_LEN_RESET = WIN_LEN_W'(10);
   localparam logic [FACTOR_W-1:0]  FACTOR_RESET  = FACTOR_W'(131072);

   // Smoothing weight: unsigned Q1.24, 1.0 included
   localparam int ALPHA_FRAC      = 24;
   localparam int ALPHA_W         = ALPHA_FRAC + 1;
   localparam int ALPHA_PRE_SHIFT = ALPHA_FRAC - 16;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = ALPHA_W'(1) << ALPHA_FRAC;

   // Blend products and accumulator
   localparam int PROD_W = ALPHA_W + DATA_W;
   localparam int ACC_W  = PROD_W + 1;
   localparam logic [ACC_W-1:0] ALPHA_HALF = ACC_W'(1) << (ALPHA_FRAC - 1);

   // Quotient bits resolved per divider cycle
   localparam int DIV_RADIX_BITS = 2;

endpackage

`default_nettype wire

// ===== hw/rtl/mavg_window_ram.sv =====
`default_nettype none

module mavg_window_ram #(
   parameter int DEPTH = 256,
   parameter int ADDR_W = 8
) (
   input  wire logic                        clock,
   input  wire logic                        wr_en,
   input  wire logic [ADDR_W-1:0]           wr_addr,
   input  wire logic [mavg_pkg::DATA_W-1:0] wr_data,
   input  wire logic                        rd_en,
   input  wire logic [ADDR_W-1:0]           rd_addr,
   output logic      [mavg_pkg::DATA_W-1:0] rd_data
);
   import mavg_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/mavg_divider.sv =====
`default_nettype none

module mavg_divider #(
   parameter int DIVIDEND_W = 40,
   parameter int DIVISOR_W = 9
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [DIVIDEND_W-1:0] dividend,
   input  wire logic [DIVISOR_W-1:0]  divisor,
   output logic                       done,
   output logic      [DIVIDEND_W-1:0] quotient
);
   import mavg_pkg::*;

   localparam int STEPS = (DIVIDEND_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS;
   localparam int PAD_W = STEPS * DIV_RADIX_BITS;
   localparam int CNT_W = $clog2(STEPS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [PAD_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dvs_ff, dvs_in;

   // Restoring division, DIV_RADIX_BITS quotient bits per cycle
   always_comb begin
      logic [DIVISOR_W:0]   r_sh;
      logic [DIVISOR_W-1:0] r;
      logic [PAD_W-1:0]     q;

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      r       = rem_ff;
      q       = quo_ff;
      r_sh    = '0;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(STEPS);
         quo_in  = PAD_W'(dividend);
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         for (int i = 0; i < DIV_RADIX_BITS; i++) begin
            r_sh = {r, q[PAD_W-1]};
            q    = {q[PAD_W-2:0], 1'b0};
            if (r_sh >= {1'b0, dvs_ff}) begin
               r_sh = r_sh - {1'b0, dvs_ff};
               q[0] = 1'b1;
            end
            r = r_sh[DIVISOR_W-1:0];
         end
         quo_in = q;
         rem_in = r;
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff[DIVIDEND_W-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/moving_average_sma_ema_top.sv =====
`default_nettype none

// Simple and exponential moving average over a stream of Q16.16 price samples.
// req channel: one price beat per sample. rsp channel: one result beat per
// sample carrying the window average (sma) and the exponential average (ema),
// each with a flag that says whether it is meaningful yet.
// csr channel: index 0 sets the window length (0 means 1, clipped to
// MAX_WINDOW) and restarts averaging; index 1 sets the Q2.16 smoothing factor,
// used from the next sample on. Other indexes are dropped. Write only when idle.
// Timing: one sample at a time. The window average (sum / N) and, once the ema
// is seeded, the smoothing weight (factor / (N + 1)) go through the one shared
// radix-4 divider in turn. Samples live in a single-port-read window RAM, read
// in the accept cycle and written back in the cycle after with the new sample.
// Reset: req and csr ready held low; window length 10, factor 2.0, sums and
// flags cleared; RAM untouched.
// A stalled rsp holds its beat in the output register; the block still takes
// the next sample and works on it, then waits with its result until the
// output register frees.

module moving_average_sma_ema_top #(
   parameter int MAX_WINDOW = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [mavg_pkg::DATA_W-1:0]     req_price,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [mavg_pkg::DATA_W-1:0]     rsp_sma_value,
   output logic                                 rsp_sma_valid,
   output logic      [mavg_pkg::DATA_W-1:0]     rsp_ema_value,
   output logic                                 rsp_ema_valid,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [mavg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mavg_pkg::CSR_DATA_W-1:0] csr_data
);
   import mavg_pkg::*;

   localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1; // window RAM address
   localparam int NW = $clog2(MAX_WINDOW + 1);                      // window length
   localparam int VW = $clog2(MAX_WINDOW + 2);                      // divisor, up to N + 1
   localparam int SW = DATA_W + $clog2(MAX_WINDOW);                 // running sum

   typedef enum logic [2:0] {
      S_IDLE,
      S_READ,
      S_SMA_DIV,
      S_ALPHA_DIV,
      S_MUL_KEEP,
      S_MUL_NEW,
      S_BLEND,
      S_OUT
   } state_type;

   // Effective window length: zero means one, clip at the RAM depth
   function automatic logic [NW-1:0] eff_len(input logic [WIN_LEN_W-1:0] len);
      logic [NW-1:0] n;
      if (len == '0) begin
         n = NW'(1);
      end else if (32'(len) > 32'(MAX_WINDOW)) begin
         n = NW'(MAX_WINDOW);
      end else begin
         n = NW'(len);
      end
      return n;
   endfunction

   state_type             state_ff, state_in;
   logic [NW-1:0]         n_ff, n_in;
   logic [FACTOR_W-1:0]   factor_ff, factor_in;
   logic [AW-1:0]         wp_ff, wp_in;
   logic [NW-1:0]         seen_ff, seen_in;
   logic [SW-1:0]         sum_ff, sum_in;
   logic [DATA_W-1:0]     ema_ff, ema_in;
   logic                  seeded_ff, seeded_in;
   logic                  sma_ok_ff, sma_ok_in;
   logic [DATA_W-1:0]     price_ff, price_in;
   logic [DATA_W-1:0]     sma_ff, sma_in;
   logic [ALPHA_W-1:0]    alpha_ff, alpha_in;
   logic [PROD_W-1:0]     prod_keep_ff, prod_keep_in;
   logic [PROD_W-1:0]     prod_new_ff, prod_new_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0]     rsp_sma_ff, rsp_sma_in;
   logic                  rsp_sma_ok_ff, rsp_sma_ok_in;
   logic [DATA_W-1:0]     rsp_ema_ff, rsp_ema_in;
   logic                  rsp_ema_ok_ff, rsp_ema_ok_in;

   logic                  req_fire;
   logic                  csr_fire;
   logic                  ram_wr_en;
   logic [DATA_W-1:0]     ram_rd_data;
   logic                  div_start;
   logic [SW-1:0]         div_dividend;
   logic [VW-1:0]         div_divisor;
   logic                  div_done;
   logic [SW-1:0]         div_quotient;

   assign req_ready = !reset && (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready = !reset && (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign ram_wr_en = (state_ff == S_READ);

   mavg_window_ram #(
      .DEPTH (MAX_WINDOW),
      .ADDR_W(AW)
   ) u_window_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(wp_ff),
      .wr_data(price_ff),
      .rd_en  (req_fire),
      .rd_addr(wp_ff),
      .rd_data(ram_rd_data)
   );

   mavg_divider #(
      .DIVIDEND_W(SW),
      .DIVISOR_W (VW)
   ) u_divider (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_quotient)
   );

   always_comb begin
      logic             full;
      logic [NW-1:0]    wp_inc;
      logic [ACC_W-1:0] blend;
      logic [ALPHA_W-1:0] keep;

      state_in      = state_ff;
      n_in          = n_ff;
      factor_in     = factor_ff;
      wp_in         = wp_ff;
      seen_in       = seen_ff;
      sum_in        = sum_ff;
      ema_in        = ema_ff;
      seeded_in     = seeded_ff;
      sma_ok_in     = sma_ok_ff;
      price_in      = price_ff;
      sma_in        = sma_ff;
      alpha_in      = alpha_ff;
      prod_keep_in  = prod_keep_ff;
      prod_new_in   = prod_new_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sma_in    = rsp_sma_ff;
      rsp_sma_ok_in = rsp_sma_ok_ff;
      rsp_ema_in    = rsp_ema_ff;
      rsp_ema_ok_in = rsp_ema_ok_ff;
      div_start     = 1'b0;
      div_dividend  = sum_in;
      div_divisor   = VW'(n_ff);
      full          = (seen_ff >= n_ff);
      wp_inc        = NW'(wp_ff) + NW'(1);
      keep          = ALPHA_ONE - alpha_ff;
      blend         = ACC_W'(prod_keep_ff) + ACC_W'(prod_new_ff) + ALPHA_HALF;

      // Drop the held beat once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Window length change restarts averaging; the RAM keeps its contents
      if (csr_fire) begin
         if (csr_index == CSR_WINDOW_LEN) begin
            n_in      = eff_len(csr_data[WIN_LEN_W-1:0]);
            sum_in    = '0;
            wp_in     = '0;
            seen_in   = '0;
            ema_in    = '0;
            seeded_in = 1'b0;
         end else if (csr_index == CSR_EMA_FACTOR) begin
            factor_in = csr_data[FACTOR_W-1:0];
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               price_in = req_price;
               state_in = S_READ;
            end
         end
         S_READ: begin
            // Oldest sample leaves the sum once the window is full
            sum_in    = sum_ff - (full ? SW'(ram_rd_data) : SW'(0)) + SW'(price_ff);
            wp_in     = (wp_inc == n_ff) ? AW'(0) : wp_inc[AW-1:0];
            seen_in   = full ? seen_ff : seen_ff + NW'(1);
            sma_ok_in = full || (seen_ff + NW'(1) == n_ff);
            sma_in    = '0;
            if (sma_ok_in) begin
               div_start    = 1'b1;
               div_dividend = sum_in;
               div_divisor  = VW'(n_ff);
               state_in     = S_SMA_DIV;
            end else begin
               state_in = S_OUT;
            end
         end
         S_SMA_DIV: begin
            if (div_done) begin
               sma_in = div_quotient[DATA_W-1:0];
               if (seeded_ff) begin
                  div_start    = 1'b1;
                  div_dividend = SW'(factor_ff) << ALPHA_PRE_SHIFT;
                  div_divisor  = VW'(n_ff) + VW'(1);
                  state_in     = S_ALPHA_DIV;
               end else begin
                  // First full window seeds the ema
                  ema_in    = div_quotient[DATA_W-1:0];
                  seeded_in = 1'b1;
                  state_in  = S_OUT;
               end
            end
         end
         S_ALPHA_DIV: begin
            if (div_done) begin
               if (div_quotient > SW'(ALPHA_ONE)) begin
                  alpha_in = ALPHA_ONE;
               end else begin
                  alpha_in = div_quotient[ALPHA_W-1:0];
               end
               state_in = S_MUL_KEEP;
            end
         end
         S_MUL_KEEP: begin
            prod_keep_in = PROD_W'(keep) * PROD_W'(ema_ff);
            state_in     = S_MUL_NEW;
         end
         S_MUL_NEW: begin
            prod_new_in = PROD_W'(alpha_ff) * PROD_W'(price_ff);
            state_in    = S_BLEND;
         end
         S_BLEND: begin
            // Round half up, saturate to 32 bits
            if (|blend[ACC_W-1:ALPHA_FRAC+DATA_W]) begin
               ema_in = '1;
            end else begin
               ema_in = blend[ALPHA_FRAC+DATA_W-1:ALPHA_FRAC];
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            // Hold the result until the output register frees
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_sma_in    = sma_ok_ff ? sma_ff : '0;
               rsp_sma_ok_in = sma_ok_ff;
               rsp_ema_in    = seeded_ff ? ema_ff : '0;
               rsp_ema_ok_in = seeded_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         n_ff         <= eff_len(WIN_LEN_RESET);
         factor_ff    <= FACTOR_RESET;
         wp_ff        <= '0;
         seen_ff      <= '0;
         sum_ff       <= '0;
         ema_ff       <= '0;
         seeded_ff    <= 1'b0;
         sma_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         factor_ff    <= factor_in;
         wp_ff        <= wp_in;
         seen_ff      <= seen_in;
         sum_ff       <= sum_in;
         ema_ff       <= ema_in;
         seeded_ff    <= seeded_in;
         sma_ok_ff    <= sma_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      price_ff      <= price_in;
      sma_ff        <= sma_in;
      alpha_ff      <= alpha_in;
      prod_keep_ff  <= prod_keep_in;
      prod_new_ff   <= prod_new_in;
      rsp_sma_ff    <= rsp_sma_in;
      rsp_sma_ok_ff <= rsp_sma_ok_in;
      rsp_ema_ff    <= rsp_ema_in;
      rsp_ema_ok_ff <= rsp_ema_ok_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sma_value = rsp_sma_ff;
   assign rsp_sma_valid = rsp_sma_ok_ff;
   assign rsp_ema_value = rsp_ema_ff;
   assign rsp_ema_valid = rsp_ema_ok_ff;

`ifndef SYNTHESIS
   a_wp_in_window: assert property (@(posedge clock) disable iff (reset)
      NW'(wp_ff) < n_ff)
      else $error("write pointer outside the window");

   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= n_ff)
      else $error("sample count beyond window length");

   a_seeded_needs_full: assert property (@(posedge clock) disable iff (reset)
      seeded_ff |-> (seen_ff == n_ff))
      else $error("ema seeded without a full window");

   a_div_done_expected: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_SMA_DIV || state_ff == S_ALPHA_DIV))
      else $error("divider result arrived outside a division state");
`endif

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

// Moving average block: checks each rsp beat against a cycle-free model of the
// window sum, the truncated window average and the rounded exponential blend.
// A short directed run covers the shortest window lengths, the smoothing weight
// clipping and the register corner cases; random streams follow, one per
// window setting, with random idles on both channels in most of them.
module testbench;
   import mavg_pkg::*;

   localparam int          WIN_MAX      = 256;
   localparam int unsigned CYCLE_LIMIT  = 10_000_000;
   localparam int          SETTLE_TICKS = 64;
   localparam logic [63:0] WEIGHT_ONE   = 64'd1 << 24;
   localparam logic [63:0] WEIGHT_HALF  = 64'd1 << 23;

   typedef struct {
      logic [DATA_W-1:0] sma_value;
      logic              sma_valid;
      logic [DATA_W-1:0] ema_value;
      logic              ema_valid;
   } average_beat_type;

   // Drive every input to a known value from time zero.
   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_valid  = 1'b0;
   logic [DATA_W-1:0]      req_price  = '0;
   logic                   rsp_ready  = 1'b0;
   logic                   csr_valid  = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   logic                   req_ready;
   logic                   rsp_valid;
   logic [DATA_W-1:0]      rsp_sma_value;
   logic                   rsp_sma_valid;
   logic [DATA_W-1:0]      rsp_ema_value;
   logic                   rsp_ema_valid;
   logic                   csr_ready;

   moving_average_sma_ema_top #(.MAX_WINDOW(WIN_MAX)) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_price     (req_price),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_sma_value (rsp_sma_value),
      .rsp_sma_valid (rsp_sma_valid),
      .rsp_ema_value (rsp_ema_value),
      .rsp_ema_valid (rsp_ema_valid),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Averaging model: our own copy of the delay line, sum, fill count,
   // exponential level and both registers.
   // ---------------------------------------------------------------------
   logic [DATA_W-1:0]    window_ram [WIN_MAX];
   logic [39:0]          window_sum;
   int unsigned          window_ptr;
   int unsigned          window_fill;
   logic [DATA_W-1:0]    ema_level;
   bit                   ema_seeded;
   logic [WIN_LEN_W-1:0] cfg_window_len;
   logic [FACTOR_W-1:0]  cfg_factor;

   average_beat_type     pending_averages [$];
   average_beat_type     oldest_average;
   int unsigned          fail_count   = 0;
   int unsigned          cycle_count  = 0;
   int unsigned          rsp_stall    = 0;
   bit                   gaps_on      = 1'b1;

   // Clear the running state; the delay line itself is kept.
   function automatic void restart_averages();
      window_sum  = '0;
      window_ptr  = 0;
      window_fill = 0;
      ema_level   = '0;
      ema_seeded  = 1'b0;
   endfunction

   function automatic int unsigned window_span();
      if (cfg_window_len == 0) return 1;
      if (cfg_window_len > WIN_MAX) return WIN_MAX;
      return 32'(cfg_window_len);
   endfunction

   // Fold one price into the window and the exponential level; return the
   // beat the block must produce for it.
   function automatic average_beat_type advance_averages(input logic [DATA_W-1:0] price);
      average_beat_type beat;
      int unsigned   n;
      int unsigned   slot;
      logic [63:0]   weight;
      logic [63:0]   blend;
      n    = window_span();
      slot = window_ptr % n;
      if (window_fill >= n) window_sum -= 40'(window_ram[slot]);
      window_sum       += 40'(price);
      window_ram[slot]  = price;
      slot++;
      window_ptr = (slot >= n) ? 0 : slot;
      if (window_fill < n) window_fill++;

      beat.sma_valid = (window_fill >= n);
      beat.sma_value = beat.sma_valid ? DATA_W'(window_sum / 40'(n)) : '0;

      if (ema_seeded) begin
         weight = (64'(cfg_factor) << 8) / 64'(n + 1);
         if (weight > WEIGHT_ONE) weight = WEIGHT_ONE;
         blend = (WEIGHT_ONE - weight) * 64'(ema_level) + weight * 64'(price) + WEIGHT_HALF;
         blend = blend >> 24;
         if (blend > 64'hFFFF_FFFF) blend = 64'hFFFF_FFFF;
         ema_level = DATA_W'(blend);
      end else if (beat.sma_valid) begin
         // seed with the first full-window average
         ema_level  = beat.sma_value;
         ema_seeded = 1'b1;
      end
      beat.ema_valid = ema_seeded;
      beat.ema_value = ema_seeded ? ema_level : '0;
      return beat;
   endfunction

   // Idle length: mostly short, now and then long.
   function automatic int unsigned idle_len();
      if ($urandom_range(0, 9) == 0) return $urandom_range(20, 70);
      return $urandom_range(1, 4);
   endfunction

   function automatic logic [DATA_W-1:0] pick_price();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return DATA_W'($urandom_range(0, 32'h0003_FFFF));
         default: return DATA_W'($urandom);
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Channel tasks
   // ---------------------------------------------------------------------

   // Send one price beat. Keep valid high across back-to-back beats so it is
   // never lowered and raised in the same step.
   task automatic send_price(input logic [DATA_W-1:0] price);
      int unsigned gap;
      gap = 0;
      if (gaps_on && $urandom_range(0, 1) == 0) gap = idle_len();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_price <= price;
      do @(posedge clock); while (!req_ready);
      pending_averages.insert(pending_averages.size(), advance_averages(price));
   endtask

   // Drop valid, wait until every result beat is back, then let the block settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_averages.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   // Register write; call only while the block is idle.
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (index == CSR_WINDOW_LEN) begin
         cfg_window_len = data[WIN_LEN_W-1:0];
         restart_averages();
      end else if (index == CSR_EMA_FACTOR) begin
         cfg_factor = data[FACTOR_W-1:0];
      end
      @(posedge clock);
   endtask

   // Random upper bits ride along; the block must ignore them.
   task automatic set_window(input int unsigned len);
      write_csr(CSR_WINDOW_LEN, ($urandom & ~32'h1FF) | CSR_DATA_W'(len));
   endtask

   task automatic set_factor(input int unsigned factor);
      write_csr(CSR_EMA_FACTOR, ($urandom & ~32'h3FFFF) | CSR_DATA_W'(factor));
   endtask

   // ---------------------------------------------------------------------
   // Result side: check each rsp beat, stall at random.
   // ---------------------------------------------------------------------
   task automatic compare_field(input string name, input logic [DATA_W-1:0] want,
                                input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_averages.size() == 0) begin
            $error("rsp beat with no sample outstanding");
            fail_count++;
         end else begin
            oldest_average = pending_averages.pop_front();
            compare_field("sma_value", oldest_average.sma_value, rsp_sma_value);
            compare_field("sma_valid", DATA_W'(oldest_average.sma_valid),
                          DATA_W'(rsp_sma_valid));
            compare_field("ema_value", oldest_average.ema_value, rsp_ema_value);
            compare_field("ema_valid", DATA_W'(oldest_average.ema_valid),
                          DATA_W'(rsp_ema_valid));
         end
      end
      // hold ready low through a stall, then pick the next one
      if (rsp_stall != 0) rsp_stall--;
      else if (gaps_on && $urandom_range(0, 3) == 0) rsp_stall = idle_len();
      rsp_ready <= (rsp_stall == 0);
   end

   // Watchdog: a hang ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset settings: window 10, factor 2.0. Fill the window with extreme
   // prices, seed the exponential average and run two updates past it.
   task automatic test_reset_window();
      logic [DATA_W-1:0] prices [12];
      prices = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFE,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'hFFFF_FFFF, 32'h0000_0000};
      foreach (prices[i]) send_price(prices[i]);
      drain_results();
   endtask

   // Window length zero (acts as 1), window 1 with zero and full factor,
   // weight landing exactly on 1.0, a factor change without restart, and
   // writes to unused indexes.
   task automatic test_short_windows();
      logic [CSR_INDEX_W-1:0] idx;
      set_window(0);
      set_factor(262143);
      send_price(32'h0012_3456);
      send_price(32'hFFFF_FFFF);
      drain_results();

      set_window(1);
      set_factor(0);
      send_price(32'h0001_0000);
      send_price(32'hFFFF_FFFF);
      send_price(32'h0000_0000);
      drain_results();

      // factor 3.0 over N+1 = 3 gives a weight of exactly one
      set_window(2);
      set_factor(3 << 16);
      send_price(32'h0004_0000);
      send_price(32'h0008_0000);
      send_price(32'hFFFF_0000);
      send_price(32'h0000_0003);
      drain_results();

      // new factor applies on the next sample, window keeps its fill
      set_factor(1);
      send_price(32'h1234_5678);
      send_price(32'h8765_4321);
      drain_results();

      // unused indexes must leave both registers alone
      for (idx = CSR_EMA_FACTOR + CSR_INDEX_W'(1); idx != 0; idx++) write_csr(idx, '1);
      send_price(32'hDEAD_BEEF);
      send_price(32'h0000_FFFF);
      drain_results();
   endtask

   // Random streams, one per window setting; the saturating lengths need a
   // full pass of the delay line, the rest stay small.
   task automatic test_random_streams();
      int unsigned lens [9];
      int unsigned len;
      int unsigned span;
      int unsigned count;
      int unsigned factor;
      lens = '{1, 0, 2, 3, 256, 5, 511, 16, 257};
      for (int phase = 0; phase < 14; phase++) begin
         len     = (phase < 9) ? lens[phase] : $urandom_range(1, 40);
         gaps_on = (phase % 4 != 3);
         set_window(len);
         span = (len == 0) ? 1 : (len > WIN_MAX) ? WIN_MAX : len;
         case (phase % 5)
            0:       factor = 0;
            1:       factor = 262143;
            2:       factor = 131072;
            3:       factor = ((span + 1) << 16 < 262144) ? (span + 1) << 16
                                                          : $urandom_range(0, 262143);
            default: factor = $urandom_range(0, 262143);
         endcase
         set_factor(factor);
         count = (span > 64) ? span + 100 : 90;
         for (int k = 0; k < count; k++) begin
            // pause mid-stream until every result is back; maybe retune
            if (k == count / 2) begin
               drain_results();
               if ($urandom_range(0, 1) == 0) set_factor($urandom_range(0, 262143));
               if ($urandom_range(0, 3) == 0)
                  write_csr(CSR_INDEX_W'($urandom_range(CSR_EMA_FACTOR + 1, 15)), $urandom);
            end
            send_price(pick_price());
         end
         drain_results();
      end
   endtask

   initial begin
      cfg_window_len = WIN_LEN_RESET;
      cfg_factor     = FACTOR_RESET;
      restart_averages();
      foreach (window_ram[i]) window_ram[i] = '0;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_window();
      test_short_windows();
      test_random_streams();

      drain_results();
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
